// ===== rtl/core/rnpa_pkg.sv =====
`default_nettype none

package rnpa_pkg;

  // Geometry and fixed-point format
  localparam int unsigned MAX_SIZE   = 1024;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned INDEX_W    = 20;
  localparam int unsigned OFS_W      = COORD_W + 1;
  localparam int unsigned PROD_W     = OFS_W + COEF_W;
  localparam int unsigned ACC_W      = PROD_W + 3;
  localparam int unsigned TRN_W      = ACC_W - FRAC_BITS;
  localparam int unsigned MUL_W      = COORD_W + SIZE_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE  = 3'd0,
    CFG_SRC_STRIDE  = 3'd1,
    CFG_DEST_STRIDE = 3'd2,
    CFG_COS_Q       = 3'd3,
    CFG_NEG_SIN_Q   = 3'd4
  } cfg_idx_e;

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [OFS_W-1:0]   ofs_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [TRN_W-1:0]   trn_t;
  typedef logic [MUL_W-1:0]          mul_t;

  // Settings seen by the datapath; size is already clamped to MAX_SIZE
  typedef struct packed {
    size_t size;
    size_t src_stride;
    size_t dest_stride;
    coef_t cos_q;
    coef_t neg_sin_q;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/rnpa_cfg.sv =====
`default_nettype none

module rnpa_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [rnpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rnpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output      rnpa_pkg::cfg_t                  cfg_o
);
  import rnpa_pkg::*;

  size_t image_size_q;
  size_t src_stride_q;
  size_t dest_stride_q;
  coef_t cos_q_q;
  coef_t neg_sin_q_q;

  assign cfg_ready_o = 1'b1;

  // Decode the register index and load on a beat; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q  <= SIZE_W'(MAX_SIZE);
      src_stride_q  <= SIZE_W'(1024);
      dest_stride_q <= SIZE_W'(1024);
      cos_q_q       <= coef_t'(65536);
      neg_sin_q_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_SIZE:  image_size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_SRC_STRIDE:  src_stride_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_DEST_STRIDE: dest_stride_q <= cfg_data_i[SIZE_W-1:0];
        CFG_COS_Q:       cos_q_q       <= $signed(cfg_data_i);
        CFG_NEG_SIN_Q:   neg_sin_q_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp oversized images to the largest supported side
  always_comb begin
    cfg_o.size        = (image_size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : image_size_q;
    cfg_o.src_stride  = src_stride_q;
    cfg_o.dest_stride = dest_stride_q;
    cfg_o.cos_q       = cos_q_q;
    cfg_o.neg_sin_q   = neg_sin_q_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rnpa_rot.sv =====
`default_nettype none

module rnpa_rot (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rnpa_pkg::cfg_t         cfg_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire rnpa_pkg::coord_t       dest_x_i,
  input  wire rnpa_pkg::coord_t       dest_y_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      rnpa_pkg::acc_t         sxq_o,
  output      rnpa_pkg::acc_t         syq_o,
  output      rnpa_pkg::index_t       dest_index_o
);
  import rnpa_pkg::*;

  logic   v1_q, v2_q, v3_q;
  logic   en1, en2, en3;

  // Stage 1: centered offsets
  coord_t x1_q, y1_q;
  ofs_t   dx_q, dy_q;
  // Stage 2: products
  prod_t  p_xc_q, p_ys_q, p_yc_q, p_xs_q;
  mul_t   dmul_q;
  coord_t x2_q;
  // Stage 3: fixed-point source position
  acc_t   sxq_q, syq_q;
  index_t didx_q;

  acc_t   centre;
  mul_t   dsum;

  // A stage moves when it is empty or its successor moves
  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Subtract half the image side to center the coordinates
  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= dest_x_i;
      y1_q <= dest_y_i;
      dx_q <= $signed(OFS_W'(dest_x_i) - OFS_W'(cfg_i.size[SIZE_W-1:1]));
      dy_q <= $signed(OFS_W'(dest_y_i) - OFS_W'(cfg_i.size[SIZE_W-1:1]));
    end
  end

  // Multiply offsets by the rotation terms and the row by the stride
  always_ff @(posedge clk_i) begin
    if (en2) begin
      p_xc_q <= dx_q * cfg_i.cos_q;
      p_ys_q <= dy_q * cfg_i.neg_sin_q;
      p_yc_q <= dy_q * cfg_i.cos_q;
      p_xs_q <= dx_q * cfg_i.neg_sin_q;
      dmul_q <= MUL_W'(y1_q) * MUL_W'(cfg_i.dest_stride);
      x2_q   <= x1_q;
    end
  end

  assign centre = $signed(ACC_W'(cfg_i.size) << (FRAC_BITS - 1));
  assign dsum   = dmul_q + MUL_W'(x2_q);

  // Sum the terms around the image center
  always_ff @(posedge clk_i) begin
    if (en3) begin
      sxq_q  <= {{(ACC_W-PROD_W){p_xc_q[PROD_W-1]}}, p_xc_q}
              + {{(ACC_W-PROD_W){p_ys_q[PROD_W-1]}}, p_ys_q} + centre;
      syq_q  <= {{(ACC_W-PROD_W){p_yc_q[PROD_W-1]}}, p_yc_q}
              - {{(ACC_W-PROD_W){p_xs_q[PROD_W-1]}}, p_xs_q} + centre;
      didx_q <= dsum[INDEX_W-1:0];
    end
  end

  assign out_valid_o  = v3_q;
  assign sxq_o        = sxq_q;
  assign syq_o        = syq_q;
  assign dest_index_o = didx_q;

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted beat did not enter stage 1");
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en3 |=> v2_q && $stable(p_xc_q) && $stable(dmul_q))
    else $error("stage 2 lost its beat while stalled");
  a_tail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_ready_i |=> v3_q && $stable(sxq_q) && $stable(didx_q))
    else $error("stage 3 changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rnpa_addr.sv =====
`default_nettype none

module rnpa_addr (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rnpa_pkg::cfg_t         cfg_i,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire rnpa_pkg::acc_t         sxq_i,
  input  wire rnpa_pkg::acc_t         syq_i,
  input  wire rnpa_pkg::index_t       dest_index_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic                   copy_o,
  output      rnpa_pkg::coord_t       src_x_o,
  output      rnpa_pkg::coord_t       src_y_o,
  output      rnpa_pkg::index_t       src_index_o,
  output      rnpa_pkg::index_t       dest_index_o
);
  import rnpa_pkg::*;

  logic   v4_q, v5_q;
  logic   en4, en5;

  trn_t   sx_t, sy_t;
  logic   in_x, in_y, in_img;

  // Stage 4: integer source position and bounds flag
  logic   copy4_q;
  coord_t sx4_q, sy4_q;
  index_t didx4_q;
  // Stage 5: output register
  logic   copy5_q;
  coord_t sx5_q, sy5_q;
  index_t sidx5_q, didx5_q;

  mul_t   smul;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign in_ready_o = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
    end
  end

  // Truncate toward zero: bump the floor when negative with a fraction
  always_comb begin
    sx_t   = $signed(sxq_i[ACC_W-1:FRAC_BITS])
           + $signed({{(TRN_W-1){1'b0}}, sxq_i[ACC_W-1] && (|sxq_i[FRAC_BITS-1:0])});
    sy_t   = $signed(syq_i[ACC_W-1:FRAC_BITS])
           + $signed({{(TRN_W-1){1'b0}}, syq_i[ACC_W-1] && (|syq_i[FRAC_BITS-1:0])});
    in_x   = !sx_t[TRN_W-1] && ($unsigned(sx_t) < TRN_W'(cfg_i.size));
    in_y   = !sy_t[TRN_W-1] && ($unsigned(sy_t) < TRN_W'(cfg_i.size));
    in_img = in_x && in_y;
  end

  // Hold zeros for skipped pixels so the index below comes out zero too
  always_ff @(posedge clk_i) begin
    if (en4) begin
      copy4_q <= in_img;
      sx4_q   <= in_img ? sx_t[COORD_W-1:0] : '0;
      sy4_q   <= in_img ? sy_t[COORD_W-1:0] : '0;
      didx4_q <= dest_index_i;
    end
  end

  assign smul = MUL_W'(sy4_q) * MUL_W'(cfg_i.src_stride) + MUL_W'(sx4_q);

  // Form the source pixel index
  always_ff @(posedge clk_i) begin
    if (en5) begin
      copy5_q <= copy4_q;
      sx5_q   <= sx4_q;
      sy5_q   <= sy4_q;
      sidx5_q <= smul[INDEX_W-1:0];
      didx5_q <= didx4_q;
    end
  end

  assign out_valid_o  = v5_q;
  assign copy_o       = copy5_q;
  assign src_x_o      = sx5_q;
  assign src_y_o      = sy5_q;
  assign src_index_o  = sidx5_q;
  assign dest_index_o = didx5_q;

`ifndef NO_ASSERTIONS
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !copy_o |-> src_x_o == '0 && src_y_o == '0 && src_index_o == '0)
    else $error("skipped pixel carries a nonzero source");
  a_stage4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !en5 |=> v4_q && $stable(copy4_q) && $stable(sx4_q) && $stable(didx4_q))
    else $error("stage 4 lost its beat while stalled");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(src_index_o)
      && $stable(dest_index_o) && $stable(copy_o))
    else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rotate_nearest_pixel_address_top.sv =====
`default_nettype none

// Each input beat passes through the register stages to the output register.
// Throughput: one pixel per cycle while not stalled; each of the five register
// stages advances when it is empty or the stage after it moves, else holds.
// Reset: valid bits clear; settings return to a 1024-pixel image and stride,
// cos = 1.0 and -sin = 0. Settings are ready for writes in every cycle.
module rotate_nearest_pixel_address_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [rnpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rnpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [rnpa_pkg::COORD_W-1:0]    dest_x_i,
  input  wire logic [rnpa_pkg::COORD_W-1:0]    dest_y_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic                            copy_o,
  output      logic [rnpa_pkg::COORD_W-1:0]    src_x_o,
  output      logic [rnpa_pkg::COORD_W-1:0]    src_y_o,
  output      logic [rnpa_pkg::INDEX_W-1:0]    src_index_o,
  output      logic [rnpa_pkg::INDEX_W-1:0]    dest_index_o
);
  import rnpa_pkg::*;

  cfg_t   cfg;
  logic   mid_valid, mid_ready;
  acc_t   mid_sxq, mid_syq;
  index_t mid_didx;

  rnpa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rnpa_rot u_rot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .dest_x_i     (dest_x_i),
    .dest_y_i     (dest_y_i),
    .out_valid_o  (mid_valid),
    .out_ready_i  (mid_ready),
    .sxq_o        (mid_sxq),
    .syq_o        (mid_syq),
    .dest_index_o (mid_didx)
  );

  rnpa_addr u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (mid_valid),
    .in_ready_o   (mid_ready),
    .sxq_i        (mid_sxq),
    .syq_i        (mid_syq),
    .dest_index_i (mid_didx),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .copy_o       (copy_o),
    .src_x_o      (src_x_o),
    .src_y_o      (src_y_o),
    .src_index_o  (src_index_o),
    .dest_index_o (dest_index_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/rotate_nearest_pixel_address_top_test.sv =====
`timescale 1ns / 1ps

module rotate_nearest_pixel_address_top_test;
  import rnpa_pkg::*;

  localparam int Q_ONE           = 1 << FRAC_BITS;
  localparam int COEF_MIN        = -(1 << (COEF_W - 1));
  localparam int COEF_MAX        = (1 << (COEF_W - 1)) - 1;
  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  localparam int SPARE_IDX_FIRST = CFG_NEG_SIN_Q + 1;
  localparam int SPARE_IDX_LAST  = (1 << CFG_IDX_W) - 1;
  localparam int RANDOM_PHASES   = 14;
  localparam int PIXELS_PER_PHASE = 125;
  localparam int TAIL_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 40;

  // One expected address beat, tagged with the destination pixel it came from
  typedef struct {
    coord_t dest_x;
    coord_t dest_y;
    logic   do_copy;
    coord_t src_x;
    coord_t src_y;
    index_t src_index;
    index_t dest_index;
  } pixel_addr_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  coord_t                dest_x_i    = '0;
  coord_t                dest_y_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  copy_o;
  coord_t                src_x_o;
  coord_t                src_y_o;
  index_t                src_index_o;
  index_t                dest_index_o;

  // Shadow copy of the settings, updated on each accepted register beat
  size_t img_size_r    = 11'd1024;
  size_t src_stride_r  = 11'd1024;
  size_t dest_stride_r = 11'd1024;
  coef_t cos_r         = 18'sd65536;
  coef_t nsin_r        = 18'sd0;

  pixel_addr_t pending_addrs[$];
  int error_count     = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int copies_seen     = 0;
  int reg_writes      = 0;
  int quiet_cycles    = 0;
  bit steady          = 1'b0;

  int size_picks [5]   = '{0, 1, 2, 1024, 2047};
  int stride_picks [4] = '{0, 1, 1024, 2047};
  int coef_picks [5]   = '{COEF_MIN, -Q_ONE, 0, Q_ONE, COEF_MAX};

  rotate_nearest_pixel_address_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .dest_x_i     (dest_x_i),
    .dest_y_i     (dest_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .copy_o       (copy_o),
    .src_x_o      (src_x_o),
    .src_y_o      (src_y_o),
    .src_index_o  (src_index_o),
    .dest_index_o (dest_index_o)
  );

  always #5 clk_i = ~clk_i;

  // Truncate a fixed-point value toward zero
  function automatic longint trunc_toward_zero(longint v);
    if (v >= 0) begin
      return v >>> FRAC_BITS;
    end
    return -((-v) >>> FRAC_BITS);
  endfunction

  // Rotate the destination pixel back into the source image
  function automatic pixel_addr_t predict_address(coord_t x, coord_t y);
    pixel_addr_t r;
    longint side, half, dx, dy, centre, cs, ns, sxq, syq, sx, sy, sidx, didx;
    side   = (img_size_r > MAX_SIZE) ? MAX_SIZE : img_size_r;
    half   = side / 2;
    dx     = longint'(x) - half;
    dy     = longint'(y) - half;
    cs     = cos_r;
    ns     = nsin_r;
    centre = side << (FRAC_BITS - 1);
    sxq    = dx * cs + dy * ns + centre;
    syq    = dy * cs - dx * ns + centre;
    sx     = trunc_toward_zero(sxq);
    sy     = trunc_toward_zero(syq);
    r.dest_x  = x;
    r.dest_y  = y;
    r.do_copy = (sx >= 0) && (sy >= 0) && (sx < side) && (sy < side);
    if (r.do_copy) begin
      sidx        = sy * longint'(src_stride_r) + sx;
      r.src_x     = sx[COORD_W-1:0];
      r.src_y     = sy[COORD_W-1:0];
      r.src_index = sidx[INDEX_W-1:0];
    end else begin
      r.src_x     = '0;
      r.src_y     = '0;
      r.src_index = '0;
    end
    didx         = longint'(y) * longint'(dest_stride_r) + longint'(x);
    r.dest_index = didx[INDEX_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(string field, longint got, longint want, pixel_addr_t e);
    if (got != want) begin
      report_mismatch($sformatf("pixel (%0d,%0d) %s: got %0d, want %0d",
                                e.dest_x, e.dest_y, field, got, want));
    end
  endtask

  // Compare every result beat with the oldest pending pixel
  always @(posedge clk_i) begin : check_results
    pixel_addr_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("result beat with no pixel pending");
      end else begin
        want = pending_addrs.pop_front();
        results_checked++;
        if (copy_o) copies_seen++;
        check_field("copy", copy_o, want.do_copy, want);
        check_field("src_x", src_x_o, want.src_x, want);
        check_field("src_y", src_y_o, want.src_y, want);
        check_field("src_index", src_index_o, want.src_index, want);
        check_field("dest_index", dest_index_o, want.dest_index, want);
      end
    end
  end

  // End the run when no channel moves a beat for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d pixels pending",
               quiet_cycles, pending_addrs.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the result side a random number of cycles before each beat
  initial begin : result_sink
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  // Send one destination pixel; valid stays high for the caller to reuse
  task automatic send_pixel(int x, int y);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dest_x_i   <= x[COORD_W-1:0];
    dest_y_i   <= y[COORD_W-1:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_addrs.push_back(predict_address(x[COORD_W-1:0], y[COORD_W-1:0]));
    pixels_sent++;
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic settle_pixels();
    in_valid_i <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_IMAGE_SIZE:  img_size_r    = data[SIZE_W-1:0];
      CFG_SRC_STRIDE:  src_stride_r  = data[SIZE_W-1:0];
      CFG_DEST_STRIDE: dest_stride_r = data[SIZE_W-1:0];
      CFG_COS_Q:       cos_r         = data;
      CFG_NEG_SIN_Q:   nsin_r        = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Drain, then write all five registers back to back
  task automatic set_config(int side, int sstride, int dstride, int cs, int ns);
    settle_pixels();
    write_reg(CFG_IMAGE_SIZE, side[CFG_DATA_W-1:0]);
    write_reg(CFG_SRC_STRIDE, sstride[CFG_DATA_W-1:0]);
    write_reg(CFG_DEST_STRIDE, dstride[CFG_DATA_W-1:0]);
    write_reg(CFG_COS_Q, cs[CFG_DATA_W-1:0]);
    write_reg(CFG_NEG_SIN_Q, ns[CFG_DATA_W-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset settings: identity mapping at the corners and alternating bits
  task automatic test_reset_identity();
    send_pixel(0, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel('h2AA, 'h155);
    send_pixel('h155, 'h2AA);
  endtask

  // Quarter turn, then the widest coefficients the registers hold
  task automatic test_coef_extremes();
    set_config(1024, 1024, 1024, 0, -Q_ONE);
    send_pixel(0, 0);
    send_pixel(COORD_MAX, 511);
    set_config(1024, 1024, 1024, COEF_MIN, COEF_MAX);
    send_pixel(COORD_MAX, 0);
    send_pixel(0, COORD_MAX);
  endtask

  // Zero size never copies; an oversized image is clamped to the maximum
  task automatic test_zero_and_oversize();
    set_config(0, 1024, 1024, Q_ONE, 0);
    send_pixel(0, 0);
    send_pixel(5, 5);
    set_config(2047, 1024, 1024, Q_ONE, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(0, 0);
  endtask

  // Odd size, destinations past the image, truncation of a small negative,
  // index wrap and zero strides
  task automatic test_edges_and_wrap();
    set_config(7, 7, 7, Q_ONE, 0);
    send_pixel(9, 2);
    send_pixel(6, 6);
    set_config(7, 7, 7, 76459, 0);
    send_pixel(0, 3);
    set_config(1024, 2047, 2047, Q_ONE, 0);
    send_pixel(COORD_MAX, COORD_MAX);
    set_config(1024, 0, 0, Q_ONE, 0);
    send_pixel(5, 5);
  endtask

  // Writes to unused indexes must leave the settings alone
  task automatic test_spare_index();
    logic [31:0] junk;
    settle_pixels();
    for (int idx = SPARE_IDX_FIRST; idx <= SPARE_IDX_LAST; idx++) begin
      junk = $urandom();
      write_reg(idx[CFG_IDX_W-1:0], junk[CFG_DATA_W-1:0]);
    end
    cfg_valid_i <= 1'b0;
    send_pixel(3, 4);
    send_pixel(1000, 17);
  endtask

  // Random phases: one setting per phase, mostly pixels inside the image
  task automatic test_random_phases();
    int kind, side, ss, ds, cs, ns, x, y;
    real root;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind   = $urandom_range(0, 3);
      steady = ($urandom_range(0, 3) == 0);
      case (kind)
        0, 1: begin
          side = (kind == 0) ? $urandom_range(1, MAX_SIZE) : $urandom_range(1, 8);
          ss   = $urandom_range(side, MAX_SIZE);
          ds   = $urandom_range(side, MAX_SIZE);
          cs   = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
          root = $sqrt(real'(Q_ONE) * real'(Q_ONE) - real'(cs) * real'(cs));
          ns   = $urandom_range(0, 1) ? int'(root) : -int'(root);
          set_config(side, ss, ds, cs, ns);
        end
        2: begin
          set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        end
        default: begin
          set_config(size_picks[$urandom_range(0, 4)], stride_picks[$urandom_range(0, 3)],
                     stride_picks[$urandom_range(0, 3)], coef_picks[$urandom_range(0, 4)],
                     coef_picks[$urandom_range(0, 4)]);
        end
      endcase
      side = (img_size_r > MAX_SIZE) ? MAX_SIZE : img_size_r;
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        if ($urandom_range(0, 29) == 0) steady = ~steady;
        if (side > 0 && $urandom_range(0, 99) < 85) begin
          x = $urandom_range(0, side - 1);
          y = $urandom_range(0, side - 1);
        end else begin
          x = $urandom_range(0, COORD_MAX);
          y = $urandom_range(0, COORD_MAX);
        end
        send_pixel(x, y);
        // Hold off now and then until the pipeline is empty
        if (i < PIXELS_PER_PHASE - 1 && $urandom_range(0, 59) == 0) settle_pixels();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_identity();
    test_coef_extremes();
    test_zero_and_oversize();
    test_edges_and_wrap();
    test_spare_index();
    test_random_phases();
    settle_pixels();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d pixels, %0d results checked (%0d copied), %0d register writes",
             pixels_sent, results_checked, copies_seen, reg_writes);
    $display("mismatches counted: %0d", error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
